// ----- design/ssid_pkg.sv -----
// shared constants, payload types and control structs for the sorted set block
package ssid_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = 6;
  localparam int VAL_W    = 32;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  typedef struct packed {
    logic                    action;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                    is_header;
    logic [CNT_W-1:0]        entry_count;
    logic signed [VAL_W-1:0] entry_value;
    logic                    dropped_full;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    logic load_item;
    logic scan;
    logic hdr;
    logic copy;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
    logic copy_done;
  } dp_sts_t;

endpackage

// ----- design/sorted_set_insert_delete.sv -----
// top level of the sorted set: insert or delete one value, then list the whole set
// an item is handled by one search pass over the entries held before and one copy pass
// over the entries held after, both through the shared read address of the entry banks
// header appears once the search is done, then one entry per cycle unless out stalls
// rst_n is synchronous and active low: the set is empty after reset, and stored
// values above the count are never read, so the banks need no clearing
module sorted_set_insert_delete (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ssid_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output ssid_pkg::out_item_t out_item
);

  import ssid_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  ssid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ssid_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ----- design/ssid_ram.sv -----
// generic single write port ram with registered read
module ssid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/ssid_ctrl.sv -----
// controller state machine: accept, scan, header, copy and emit
module ssid_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ssid_pkg::dp_sts_t sts,
  output ssid_pkg::dp_cmd_t cmd
);

  import ssid_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_HDR  = 2'd2;
  localparam logic [1:0] S_COPY = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_HDR;
        end
      end
      S_HDR: begin
        if (sts.out_free) begin
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        if (sts.copy_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready      = (state_r == S_IDLE);
  assign cmd.load_item = (state_r == S_IDLE) && in_valid;
  assign cmd.scan      = (state_r == S_SCAN);
  assign cmd.hdr       = (state_r == S_HDR);
  assign cmd.copy      = (state_r == S_COPY);

endmodule

// ----- design/ssid_dp.sv -----
// datapath: ping-pong entry banks, search registers, merge copy and output register
module ssid_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  ssid_pkg::in_item_t  in_item,
  input  ssid_pkg::dp_cmd_t   cmd,
  output ssid_pkg::dp_sts_t   sts,
  output logic                out_valid,
  input  logic                out_ready,
  output ssid_pkg::out_item_t out_item
);

  import ssid_pkg::*;

  logic                    act_r;
  logic signed [VAL_W-1:0] val_r;
  logic [CNT_W-1:0]        count_r;
  logic                    bank_r;

  logic [CNT_W-1:0]        ridx_r;
  logic [CNT_W-1:0]        rix_r;
  logic                    rv_r;
  logic                    hit_r;
  logic [CNT_W-1:0]        pos_r;
  logic                    found_r;

  logic [CNT_W-1:0]        new_cnt_r;
  logic                    drop_r;
  logic                    do_ins_r;
  logic                    do_del_r;

  logic [CNT_W-1:0]        a_r;
  logic [CNT_W-1:0]        b_r;
  logic                    bv_r;

  logic                    out_valid_r;
  out_item_t               out_item_r;

  logic [VAL_W-1:0]        rdata0;
  logic [VAL_W-1:0]        rdata1;
  logic signed [VAL_W-1:0] rd;
  logic [IDX_W-1:0]        raddr;
  logic [CNT_W-1:0]        sel;
  logic [CNT_W-1:0]        src;
  logic                    out_free;
  logic                    advance;
  logic                    scan_done;
  logic                    copy_done;
  logic                    hdr_load;
  logic                    ent_load;
  logic signed [VAL_W-1:0] elem;
  logic                    ins;
  logic                    del;
  logic                    full;

  assign rd        = bank_r ? $signed(rdata1) : $signed(rdata0);
  assign out_free  = !out_valid_r || out_ready;
  assign advance   = !bv_r || out_free;
  assign scan_done = (ridx_r >= count_r) && !rv_r;
  assign copy_done = (a_r >= new_cnt_r) && !bv_r;
  assign hdr_load  = cmd.hdr && out_free;
  assign ent_load  = cmd.copy && bv_r && out_free;
  assign elem      = (do_ins_r && (b_r == pos_r)) ? val_r : rd;

  assign ins  = (act_r == ACT_INSERT) && !found_r;
  assign del  = (act_r == ACT_DELETE) && found_r;
  assign full = (count_r == CNT_W'(CAPACITY));

  // old-array position feeding each new position
  always_comb begin
    sel = advance ? a_r : b_r;
    if (do_ins_r) begin
      src = (sel < pos_r) ? sel : sel - CNT_W'(1);
    end else if (do_del_r) begin
      src = (sel < pos_r) ? sel : sel + CNT_W'(1);
    end else begin
      src = sel;
    end
    raddr = cmd.scan ? ridx_r[IDX_W-1:0] : src[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      bank_r      <= 1'b0;
      rv_r        <= 1'b0;
      hit_r       <= 1'b0;
      bv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_item) begin
        ridx_r  <= '0;
        rv_r    <= 1'b0;
        hit_r   <= 1'b0;
        found_r <= 1'b0;
        pos_r   <= count_r;
      end

      if (cmd.scan) begin
        rv_r  <= (ridx_r < count_r);
        rix_r <= ridx_r;
        if (ridx_r < count_r) begin
          ridx_r <= ridx_r + CNT_W'(1);
        end
        if (rv_r && !hit_r && (rd >= val_r)) begin
          pos_r   <= rix_r;
          found_r <= (rd == val_r);
          hit_r   <= 1'b1;
        end
        if (scan_done) begin
          drop_r   <= ins && full;
          do_ins_r <= ins && !full;
          do_del_r <= del;
          if (ins && !full) begin
            new_cnt_r <= count_r + CNT_W'(1);
          end else if (del) begin
            new_cnt_r <= count_r - CNT_W'(1);
          end else begin
            new_cnt_r <= count_r;
          end
        end
      end

      if (hdr_load) begin
        a_r  <= '0;
        bv_r <= 1'b0;
      end

      if (cmd.copy) begin
        if (advance) begin
          bv_r <= (a_r < new_cnt_r);
          b_r  <= a_r;
          if (a_r < new_cnt_r) begin
            a_r <= a_r + CNT_W'(1);
          end
        end
        if (copy_done) begin
          bank_r  <= ~bank_r;
          count_r <= new_cnt_r;
        end
      end

      if (hdr_load || ent_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // transaction payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      act_r <= in_item.action;
      val_r <= in_item.value;
    end
    if (hdr_load) begin
      out_item_r.is_header    <= 1'b1;
      out_item_r.entry_count  <= new_cnt_r;
      out_item_r.entry_value  <= '0;
      out_item_r.dropped_full <= drop_r;
      out_item_r.last         <= (new_cnt_r == '0);
    end else if (ent_load) begin
      out_item_r.is_header    <= 1'b0;
      out_item_r.entry_count  <= new_cnt_r;
      out_item_r.entry_value  <= elem;
      out_item_r.dropped_full <= drop_r;
      out_item_r.last         <= (b_r == new_cnt_r - CNT_W'(1));
    end
  end

  ssid_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_bank0 (
    .clk     (clk),
    .wr_en   (ent_load && bank_r),
    .wr_addr (b_r[IDX_W-1:0]),
    .wr_data (elem),
    .rd_addr (raddr),
    .rd_data (rdata0)
  );

  ssid_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_bank1 (
    .clk     (clk),
    .wr_en   (ent_load && !bank_r),
    .wr_addr (b_r[IDX_W-1:0]),
    .wr_data (elem),
    .rd_addr (raddr),
    .rd_data (rdata1)
  );

  assign sts.scan_done = scan_done;
  assign sts.out_free  = out_free;
  assign sts.copy_done = copy_done;
  assign out_valid     = out_valid_r;
  assign out_item      = out_item_r;

endmodule
